FILE: rtl/lrup_pkg.sv
package lrup_pkg;

  // Fixed field widths of the channel words.
  localparam int PAGE_W      = 20;
  localparam int FRAME_IDX_W = 4;
  localparam int CNT_W       = 32;
  localparam int CFG_W       = 5;

  localparam logic [CFG_W-1:0] NUM_FRAMES_RESET = 5'd16;
  localparam logic [CNT_W-1:0] CNT_MAX          = '1;

  // One page reference.
  typedef struct packed {
    logic [PAGE_W-1:0] page_number;
    logic              last_reference;
  } in_word_t;

  // One result.
  typedef struct packed {
    logic                   hit;
    logic [FRAME_IDX_W-1:0] frame_index;
    logic                   filled_empty;
    logic [CNT_W-1:0]       fault_count;
    logic                   sequence_done;
  } out_word_t;

endpackage

FILE: rtl/lrup_frame_mem.sv
module lrup_frame_mem import lrup_pkg::*; #(
  parameter int DEPTH = 16,
  parameter int DW    = 52,
  parameter int AW    = 4
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  // Page number and last-use stamp of each frame, one entry per frame.
  logic [DW-1:0] frame_mem_r [DEPTH];
  logic [DW-1:0] rdata_r;

  // Single write port.
  always_ff @(posedge clk) begin
    if (we) begin
      frame_mem_r[waddr] <= wdata;
    end
  end

  // Single read port with registered data.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= frame_mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/lru_page_replacement.sv
// LRU page replacement. Each input word is one page reference; each produces exactly one
// result word giving hit or miss, the frame that now holds the page, whether an empty frame
// was filled, and the saturating fault count of the current sequence. Page numbers and
// last-use stamps live in a frame memory with one read and one write port. A word is
// accepted, each frame in use (num_frames clamped to 1..MAX_FRAMES) is read, one per cycle,
// the last read is compared once it returns, and an update step writes the chosen frame
// back, waiting while the previous result is not taken; no new word is accepted until then.
// A word flagged last_reference ends the sequence: after its result, all frames become
// empty and both counters return to zero. The user must see that num_frames is written
// through the cfg port while no word is in flight; the block has no guard. It resets to 16.
module lru_page_replacement import lrup_pkg::*; #(
  parameter int MAX_FRAMES = 16,
  parameter int PAGE_BITS  = 20
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_word_t         in_word,
  output logic             out_valid,
  input  logic             out_ready,
  output out_word_t        out_word,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CFG_W-1:0] cfg_data
);

  localparam int FW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int CW = $clog2(MAX_FRAMES + 1);
  localparam int DW = PAGE_BITS + CNT_W;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SCAN   = 3'b010,
    ST_FINISH = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  logic [CFG_W-1:0]     num_frames_r;
  logic [CW-1:0]        n_frames;
  logic [FW-1:0]        last_idx;

  logic [PAGE_BITS-1:0] key_r;
  logic                 last_r;
  logic [MAX_FRAMES-1:0] valid_r;
  logic [CNT_W-1:0]     ref_time_r, ref_time_nxt;
  logic [CNT_W-1:0]     faults_r, faults_nxt;

  logic [CW-1:0]        iss_idx_r;
  logic [FW-1:0]        cmp_idx_r;
  logic                 cmp_vld_r;

  logic                 hit_found_r;
  logic [FW-1:0]        hit_slot_r;
  logic                 empty_found_r;
  logic [FW-1:0]        empty_slot_r;
  logic [CNT_W-1:0]     old_time_r;
  logic [FW-1:0]        old_slot_r;

  logic                 out_valid_r;
  out_word_t            out_word_r;

  logic                 mem_re;
  logic                 mem_we;
  logic [DW-1:0]        mem_rdata;
  logic [PAGE_BITS-1:0] rd_page;
  logic [CNT_W-1:0]     rd_time;
  logic                 rd_valid;
  logic [FW-1:0]        slot;
  logic                 in_fire;
  logic                 finish_go;

  // Configuration register: always ready. It is to be written only between words; the block does not enforce this.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_frames_r <= NUM_FRAMES_RESET;
    end else if (cfg_valid) begin
      num_frames_r <= cfg_data;
    end
  end

  // Frames in use: zero acts as one, anything above the maximum as the maximum.
  always_comb begin
    if (num_frames_r == '0) begin
      n_frames = CW'(1);
    end else if (int'(num_frames_r) > MAX_FRAMES) begin
      n_frames = CW'(MAX_FRAMES);
    end else begin
      n_frames = CW'(num_frames_r);
    end
  end

  assign last_idx = FW'(n_frames - CW'(1));

  // Handshakes.
  assign in_ready  = (state_r == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign finish_go = (state_r == ST_FINISH) && (!out_valid_r || out_ready);

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (cmp_vld_r && (cmp_idx_r == last_idx)) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (finish_go) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Latch the reference on acceptance.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      key_r  <= PAGE_BITS'(in_word.page_number);
      last_r <= in_word.last_reference;
    end
  end

  // Read issue: one frame a cycle, compare stage follows in the next cycle.
  assign mem_re = (state_r == ST_SCAN) && (iss_idx_r < n_frames);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iss_idx_r <= '0;
      cmp_vld_r <= 1'b0;
    end else begin
      cmp_vld_r <= mem_re;
      if (in_fire) begin
        iss_idx_r <= '0;
      end else if (mem_re) begin
        iss_idx_r <= iss_idx_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      cmp_idx_r <= iss_idx_r[FW-1:0];
    end
  end

  assign rd_page  = mem_rdata[DW-1:CNT_W];
  assign rd_time  = mem_rdata[CNT_W-1:0];
  assign rd_valid = valid_r[cmp_idx_r];

  // Scan: first match, first empty frame and oldest stamp (lowest index wins ties).
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_found_r   <= 1'b0;
      empty_found_r <= 1'b0;
    end else if (in_fire) begin
      hit_found_r   <= 1'b0;
      empty_found_r <= 1'b0;
    end else if (cmp_vld_r) begin
      if (rd_valid && (rd_page == key_r) && !hit_found_r) begin
        hit_found_r <= 1'b1;
      end
      if (!rd_valid && !empty_found_r) begin
        empty_found_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmp_vld_r) begin
      if (rd_valid && (rd_page == key_r) && !hit_found_r) begin
        hit_slot_r <= cmp_idx_r;
      end
      if (!rd_valid && !empty_found_r) begin
        empty_slot_r <= cmp_idx_r;
      end
      if ((cmp_idx_r == '0) || (rd_time < old_time_r)) begin
        old_time_r <= rd_time;
        old_slot_r <= cmp_idx_r;
      end
    end
  end

  // Update: choose the frame and bump the saturating counters, or clear them when a sequence ends.
  always_comb begin
    if (hit_found_r) begin
      slot = hit_slot_r;
    end else if (empty_found_r) begin
      slot = empty_slot_r;
    end else begin
      slot = old_slot_r;
    end
  end

  always_comb begin
    faults_nxt = faults_r;
    if (!hit_found_r && (faults_r != CNT_MAX)) begin
      faults_nxt = faults_r + CNT_W'(1);
    end
    ref_time_nxt = ref_time_r;
    if (ref_time_r != CNT_MAX) begin
      ref_time_nxt = ref_time_r + CNT_W'(1);
    end
  end

  assign mem_we = finish_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      ref_time_r <= '0;
      faults_r   <= '0;
    end else if (finish_go) begin
      if (last_r) begin
        valid_r    <= '0;
        ref_time_r <= '0;
        faults_r   <= '0;
      end else begin
        valid_r[slot] <= 1'b1;
        ref_time_r    <= ref_time_nxt;
        faults_r      <= faults_nxt;
      end
    end
  end

  // Output word register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (finish_go) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish_go) begin
      out_word_r.hit           <= hit_found_r;
      out_word_r.frame_index   <= FRAME_IDX_W'(slot);
      out_word_r.filled_empty  <= !hit_found_r && empty_found_r;
      out_word_r.fault_count   <= faults_nxt;
      out_word_r.sequence_done <= last_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  lrup_frame_mem #(
    .DEPTH (MAX_FRAMES),
    .DW    (DW),
    .AW    (FW)
  ) u_frame_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (slot),
    .wdata ({key_r, ref_time_r}),
    .re    (mem_re),
    .raddr (iss_idx_r[FW-1:0]),
    .rdata (mem_rdata)
  );

  // A fresh result word only ever comes out of the update cycle.
  a_out_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_FINISH))
    else $error("result word raised outside the update cycle");

  // Faults are counted at most once per reference, so they never exceed the reference count.
  a_faults_le_time: assert property (@(posedge clk) disable iff (!rst_n)
    faults_r <= ref_time_r)
    else $error("fault count ahead of reference counter");

  // The frame chosen as empty really is empty at update time.
  a_empty_is_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FINISH) && empty_found_r |-> !valid_r[empty_slot_r])
    else $error("empty frame choice points at a valid frame");

  // A hit always refers to a valid frame.
  a_hit_is_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FINISH) && hit_found_r |-> valid_r[hit_slot_r])
    else $error("hit recorded on an invalid frame");

endmodule

FILE: tb/lru_frame_checker.sv
`timescale 1ns / 1ps

// Watches the three channels of the LRU page replacement block. It keeps its own copy of
// the frame table and counters, predicts one result word per accepted reference word, and
// compares every accepted result word against the oldest prediction still waiting.
module lru_frame_checker import lrup_pkg::*; #(
  parameter int MAX_FRAMES = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_ready,
  input  in_word_t         in_word,
  input  logic             out_valid,
  input  logic             out_ready,
  input  out_word_t        out_word,
  input  logic             cfg_valid,
  input  logic             cfg_ready,
  input  logic [CFG_W-1:0] cfg_data,
  output int               mismatch_count,
  output int               results_pending
);

  // Shadow copy of the block's configuration and frame table.
  logic [CFG_W-1:0]  frames_cfg;
  logic [PAGE_W-1:0] page_of   [MAX_FRAMES];
  logic              resident  [MAX_FRAMES];
  logic [CNT_W-1:0]  stamp     [MAX_FRAMES];
  logic [CNT_W-1:0]  ref_clock;
  logic [CNT_W-1:0]  fault_total;

  out_word_t predicted_results[$];
  int        errors = 0;

  // Ending a sequence empties every frame and restarts both counters.
  function automatic void clear_sequence();
    for (int k = 0; k < MAX_FRAMES; k++) begin
      resident[k] = 1'b0;
    end
    ref_clock   = '0;
    fault_total = '0;
  endfunction

  // Works out the result word of one reference and updates the shadow table.
  function automatic out_word_t predict_reference(in_word_t w);
    out_word_t        r;
    int               n;
    int               slot;
    bit               found;
    bit               empty;
    logic [CNT_W-1:0] oldest;
    if (frames_cfg == 0) begin
      n = 1;
    end else if (frames_cfg > MAX_FRAMES) begin
      n = MAX_FRAMES;
    end else begin
      n = int'(frames_cfg);
    end
    slot  = 0;
    found = 1'b0;
    empty = 1'b0;

    // Look for the page among the frames in use.
    for (int k = 0; k < n && !found; k++) begin
      if (resident[k] && page_of[k] == w.page_number) begin
        found = 1'b1;
        slot  = k;
      end
    end

    if (found) begin
      stamp[slot] = ref_clock;
    end else begin
      if (fault_total != CNT_MAX) begin
        fault_total = fault_total + CNT_W'(1);
      end
      // The lowest empty frame is taken first.
      for (int k = 0; k < n && !empty; k++) begin
        if (!resident[k]) begin
          empty = 1'b1;
          slot  = k;
        end
      end
      // Otherwise the least recently used frame goes, the lowest index winning a tie.
      if (!empty) begin
        oldest = stamp[0];
        for (int k = 1; k < n; k++) begin
          if (stamp[k] < oldest) begin
            oldest = stamp[k];
            slot   = k;
          end
        end
      end
      page_of[slot]  = w.page_number;
      resident[slot] = 1'b1;
      stamp[slot]    = ref_clock;
    end

    if (ref_clock != CNT_MAX) begin
      ref_clock = ref_clock + CNT_W'(1);
    end

    r.hit           = found;
    r.frame_index   = FRAME_IDX_W'(slot);
    r.filled_empty  = empty;
    r.fault_count   = fault_total;
    r.sequence_done = w.last_reference;

    if (w.last_reference) begin
      clear_sequence();
    end
    return r;
  endfunction

  // Handshakes are taken at the clock edge; the counts go out by nonblocking assignment.
  always @(posedge clk) begin
    out_word_t want;
    if (!rst_n) begin
      frames_cfg = NUM_FRAMES_RESET;
      clear_sequence();
      predicted_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        frames_cfg = cfg_data;
      end
      if (in_valid && in_ready) begin
        predicted_results.push_back(predict_reference(in_word));
      end
      if (out_valid && out_ready) begin
        if (predicted_results.size() == 0) begin
          errors++;
          if (errors <= 10) begin
            $display("%0t: unexpected result: hit=%0d frame=%0d filled=%0d faults=%0d done=%0d",
                     $realtime, out_word.hit, out_word.frame_index, out_word.filled_empty,
                     out_word.fault_count, out_word.sequence_done);
          end
        end else begin
          want = predicted_results.pop_front();
          if (out_word.hit !== want.hit || out_word.frame_index !== want.frame_index ||
              out_word.filled_empty !== want.filled_empty ||
              out_word.fault_count !== want.fault_count ||
              out_word.sequence_done !== want.sequence_done) begin
            errors++;
            if (errors <= 10) begin
              $display("%0t: expected hit=%0d frame=%0d filled=%0d faults=%0d done=%0d",
                       $realtime, want.hit, want.frame_index, want.filled_empty,
                       want.fault_count, want.sequence_done);
              $display("%0t: got      hit=%0d frame=%0d filled=%0d faults=%0d done=%0d",
                       $realtime, out_word.hit, out_word.frame_index, out_word.filled_empty,
                       out_word.fault_count, out_word.sequence_done);
            end
          end
        end
      end
    end
    mismatch_count  <= errors;
    results_pending <= predicted_results.size();
  end

endmodule

FILE: tb/tb_lru_page_replacement.sv
`timescale 1ns / 1ps

module tb_lru_page_replacement import lrup_pkg::*; ();

  localparam int ITEM_TARGET    = 1650;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 40;

  logic             clk       = 1'b0;
  logic             rst_n     = 1'b0;
  logic             in_valid  = 1'b0;
  logic             in_ready;
  in_word_t         in_word   = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  out_word_t        out_word;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [CFG_W-1:0] cfg_data  = '0;

  int mismatch_count;
  int results_pending;
  int words_sent   = 0;
  int idle_cycles  = 0;
  int stall_left   = 0;
  bit rx_idle_en   = 1'b0;
  bit tx_idle_en   = 1'b0;

  lru_page_replacement dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  lru_frame_checker #(.MAX_FRAMES(16)) u_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_word         (in_word),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_word        (out_word),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data),
    .mismatch_count  (mismatch_count),
    .results_pending (results_pending)
  );

  always #10 clk = ~clk;

  // Result side: random stalls on out_ready while enabled.
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= (stall_left == 1);
    end else if (rx_idle_en && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(1, 15);
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Counts the cycles in which no word moves on any channel.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic in_word_t ref_of(logic [PAGE_W-1:0] page, logic last);
    in_word_t w;
    w.page_number    = page;
    w.last_reference = last;
    return w;
  endfunction

  // Offers one reference word and holds it until taken, then perhaps idles for a burst.
  task automatic push_ref(in_word_t w);
    in_valid <= 1'b1;
    in_word  <= w;
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
    words_sent++;
    if (tx_idle_en && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
  endtask

  // Stops sending and waits until every predicted result word has come back.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_pending != 0) begin
      @(posedge clk);
    end
  endtask

  task automatic set_frames(logic [CFG_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) begin
      @(posedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [PAGE_W-1:0] pool [24];
    logic [CFG_W-1:0]  extremes [5];
    logic [PAGE_W-1:0] page;
    int                pool_size;
    int                seq_left;
    int                phase;
    int                phase_len;
    bit                last;
    bit                final_stretch;

    extremes  = '{5'd1, 5'd16, 5'd0, 5'd31, 5'd17};
    seq_left  = 0;
    pool_size = 1;
    phase     = 0;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Default of sixteen frames: extreme page numbers, hits and a closing reference.
    push_ref(ref_of(20'h00000, 1'b0));
    push_ref(ref_of(20'hFFFFF, 1'b0));
    push_ref(ref_of(20'h00000, 1'b0));
    push_ref(ref_of(20'h12345, 1'b0));
    push_ref(ref_of(20'hFFFFF, 1'b0));
    push_ref(ref_of(20'h00000, 1'b1));

    // A frame count of zero behaves as a single frame, so every miss replaces frame 0.
    drain();
    set_frames(5'd0);
    push_ref(ref_of(20'h00005, 1'b0));
    push_ref(ref_of(20'h00005, 1'b0));
    push_ref(ref_of(20'h00006, 1'b0));
    push_ref(ref_of(20'h00005, 1'b0));
    push_ref(ref_of(20'h00006, 1'b1));

    // Three frames: fill, hit, then evict the least recently used twice.
    drain();
    set_frames(5'd3);
    push_ref(ref_of(20'h00001, 1'b0));
    push_ref(ref_of(20'h00002, 1'b0));
    push_ref(ref_of(20'h00003, 1'b0));
    push_ref(ref_of(20'h00001, 1'b0));
    push_ref(ref_of(20'h00004, 1'b0));
    push_ref(ref_of(20'h00002, 1'b0));

    // A count above the maximum acts as sixteen; the sequence carries on into empty frames.
    drain();
    set_frames(5'd31);
    push_ref(ref_of(20'h00007, 1'b0));
    push_ref(ref_of(20'h00008, 1'b0));

    // Shrinking mid-sequence hides the upper frames, so page 8 misses again.
    drain();
    set_frames(5'd2);
    push_ref(ref_of(20'h00008, 1'b0));
    push_ref(ref_of(20'h00001, 1'b1));

    // Random phases: sequences over a small working set, with some stray pages.
    while (words_sent < ITEM_TARGET) begin
      drain();
      set_frames(phase < 5 ? extremes[phase] : CFG_W'($urandom_range(0, 31)));
      phase++;
      final_stretch = (ITEM_TARGET - words_sent) <= 150;
      tx_idle_en    = !final_stretch && ($urandom_range(0, 3) != 0);
      rx_idle_en   <= !final_stretch && ($urandom_range(0, 3) != 0);
      phase_len     = $urandom_range(60, 140);
      repeat (phase_len) begin
        if (seq_left == 0) begin
          pool_size = $urandom_range(1, 20);
          for (int k = 0; k < pool_size; k++) begin
            case ($urandom_range(0, 15))
              0:       pool[k] = '0;
              1:       pool[k] = '1;
              default: pool[k] = PAGE_W'($urandom_range(0, 20'hFFFFF));
            endcase
          end
          seq_left = $urandom_range(1, 80);
        end
        if ($urandom_range(0, 99) < 88) begin
          page = pool[$urandom_range(0, pool_size - 1)];
        end else begin
          page = PAGE_W'($urandom_range(0, 20'hFFFFF));
        end
        // Now and then a sequence is cut short by an early closing reference.
        last = (seq_left == 1) || ($urandom_range(0, 99) == 0);
        seq_left = last ? 0 : seq_left - 1;
        push_ref(ref_of(page, last));
      end
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && results_pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/lrup_pkg.sv
rtl/lrup_frame_mem.sv
rtl/lru_page_replacement.sv
tb/lru_frame_checker.sv
tb/tb_lru_page_replacement.sv
